@@ hw/rtl/tpt_pkg.sv @@
package tpt_pkg;

  // Operand width of the serial multiplier and quotient width of the divider
  localparam int unsigned MUL_W = 18;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned DIV_W = 9;
  localparam int unsigned QUO_W = 16;
  // Reciprocal table entry i is 2^NUM_EXP / (64 + i)
  localparam int unsigned NUM_EXP = 21;

  localparam int CLIP_KNEE = 2304;
  localparam int CLIP_RAIL = 3072;

  function automatic logic signed [12:0] soft_limit(input logic signed [20:0] v);
    logic        [21:0] m;
    logic        [21:0] r;
    logic signed [21:0] res;
    m = v[20] ? 22'(-$signed({v[20], v})) : 22'({1'b0, v});
    r = m;
    if (m > 22'(CLIP_KNEE)) begin
      r = 22'(CLIP_KNEE) + ((m - 22'(CLIP_KNEE)) >> 3);
    end
    if (r > 22'(CLIP_RAIL)) begin
      r = 22'(CLIP_RAIL);
    end
    res = v[20] ? -$signed(r) : $signed(r);
    return res[12:0];
  endfunction

endpackage

@@ hw/rtl/tpt_mul.sv @@
module tpt_mul
  import tpt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic                     done,
  output logic signed [PROD_W-1:0] p
);

  localparam int unsigned CNT_W = $clog2(MUL_W);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic signed [MUL_W:0]  hi;
  logic [MUL_W-1:0]       lo;
  logic signed [MUL_W:0]  a_ext;
  logic signed [MUL_W:0]  addend;
  logic signed [MUL_W:0]  sum;

  // Shift-add one multiplier bit a cycle; the sign bit weighs negative
  always_comb begin
    addend = '0;
    if (lo[0]) begin
      addend = (cnt == CNT_W'(MUL_W - 1)) ? -a_ext : a_ext;
    end
    sum = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        hi    <= '0;
        lo    <= b;
        a_ext <= {a[MUL_W-1], a};
      end else if (busy) begin
        hi <= {sum[MUL_W], sum[MUL_W:1]};
        lo <= {sum[0], lo[MUL_W-1:1]};
        if (cnt == CNT_W'(MUL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign p = {hi[MUL_W-1:0], lo};

endmodule

@@ hw/rtl/tpt_div.sv @@
module tpt_div
  import tpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int unsigned STEPS = NUM_EXP + 1;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] d;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  // Restoring division of 2^NUM_EXP, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem, (cnt == '0)};
    fits   = rem_sh >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= '0;
        d    <= divisor;
      end else if (busy) begin
        rem <= fits ? DIV_W'(rem_sh - {1'b0, d}) : rem_sh[DIV_W-1:0];
        quo <= {quo[QUO_W-2:0], fits};
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/tpt_ladder_lowpass_filter.sv @@
// Channel  Direction  Fields                                  Handshake
// input    in         sample_in, cutoff_gain, resonance_gain  in_valid / in_ready
// output   out        sample_out                              out_valid / out_ready
//
// One word takes 16 or 17 multiplies on the shared bit-serial multiplier and one or
// two divisions for the reciprocal, each operation with an issue and a write-back step:
// 16 multiplies and one division when the denominator clamps at the top of the table,
// 17 and two otherwise. Each word runs to the end before the next one is taken.
// Reset clears the four stage memories and the output register.
// A new word is taken once the last finished result has moved to the output
// register; a stalled output holds the block in its final step.
module tpt_ladder_lowpass_filter
  import tpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample_in,
  input  logic [14:0]        cutoff_gain,
  input  logic [13:0]        resonance_gain,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [12:0] sample_out
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6,
    ST_G2, ST_G4, ST_DEN, ST_DIVA, ST_DIVB, ST_INTP,
    ST_KC, ST_DRV, ST_S0, ST_S1, ST_S2, ST_S3
  } step_t;

  state_t state;
  step_t  step;

  logic signed [15:0]       x;
  logic [14:0]              g;
  logic [13:0]              k;
  logic signed [12:0]       s [4];
  logic signed [MUL_W-1:0]  c;
  logic signed [MUL_W-1:0]  t;
  logic [15:0]              g2;
  logic [8:0]               idx;
  logic [8:0]               frac;
  logic [QUO_W-1:0]         ra;
  logic [QUO_W-1:0]         rb;
  logic signed [MUL_W-1:0]  rc;
  logic signed [MUL_W-1:0]  drv;
  logic signed [12:0]       out_q;

  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic                     is_div;
  logic                     mul_start;
  logic                     div_start;
  logic                     mul_done;
  logic                     div_done;
  logic signed [PROD_W-1:0] p;
  logic [QUO_W-1:0]         quo;
  logic [DIV_W-1:0]         divisor;
  logic signed [MUL_W-1:0]  omg;
  logic signed [20:0]       p15;
  logic signed [23:0]       p12;
  logic signed [26:0]       p9;
  logic [23:0]              den;
  logic [17:0]              off;
  logic signed [12:0]       s_cur;
  logic signed [MUL_W-1:0]  y;
  logic signed [20:0]       dsc;

  assign omg = 18'sd32768 - $signed({3'b000, g});
  assign p15 = p[PROD_W-1:15];
  assign p12 = p[PROD_W-1:12];
  assign p9  = p[PROD_W-1:9];

  always_comb begin
    is_div = (step == ST_DIVA) || (step == ST_DIVB);
    divisor = (step == ST_DIVB) ? DIV_W'({1'b0, idx} + 10'd65) : DIV_W'({1'b0, idx} + 10'd64);
    s_cur = s[0];
    case (step)
      ST_S1:   s_cur = s[1];
      ST_S2:   s_cur = s[2];
      ST_S3:   s_cur = s[3];
      default: s_cur = s[0];
    endcase
    op_a = '0;
    op_b = '0;
    case (step)
      ST_C0:   begin op_a = omg; op_b = MUL_W'(s[0]); end
      ST_C2:   begin op_a = omg; op_b = MUL_W'(s[1]); end
      ST_C4:   begin op_a = omg; op_b = MUL_W'(s[2]); end
      ST_C6:   begin op_a = omg; op_b = MUL_W'(s[3]); end
      ST_C1, ST_C3, ST_C5: begin
        op_a = $signed({3'b000, g}); op_b = c;
      end
      ST_G2:   begin op_a = $signed({3'b000, g}); op_b = $signed({3'b000, g}); end
      ST_G4:   begin op_a = $signed({2'b00, g2}); op_b = $signed({2'b00, g2}); end
      ST_DEN:  begin op_a = $signed({4'b0000, k}); op_b = $signed({2'b00, g2}); end
      ST_INTP: begin
        op_a = $signed({2'b00, rb}) - $signed({2'b00, ra});
        op_b = $signed({9'd0, frac});
      end
      ST_KC:   begin op_a = $signed({4'b0000, k}); op_b = c; end
      ST_DRV:  begin op_a = drv; op_b = rc; end
      ST_S0, ST_S1, ST_S2, ST_S3: begin
        op_a = drv - MUL_W'(s_cur); op_b = $signed({3'b000, g});
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
    // Clamp the denominator at the top of the table
    den = 24'd32768 + 24'(p12);
    if (den > 24'd163840) begin
      den = 24'd163840;
    end
    off = 18'(den - 24'd32768);
    y   = MUL_W'(p15) + MUL_W'(s_cur);
    dsc = 21'(p15) + 21'(p15 >>> 3);
    mul_start = (state == S_ISSUE) && !is_div;
    div_start = (state == S_ISSUE) && is_div;
  end

  tpt_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .p     (p)
  );

  tpt_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (divisor),
    .done    (div_done),
    .quo     (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_C0;
      out_valid <= 1'b0;
      out_q     <= '0;
      for (int i = 0; i < 4; i++) begin
        s[i] <= '0;
      end
    end else begin
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= sample_in;
            g     <= cutoff_gain;
            k     <= resonance_gain;
            step  <= ST_C0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if ((is_div && div_done) || (!is_div && mul_done)) begin
            case (step)
              ST_C0: c <= MUL_W'(p15);
              ST_C1, ST_C3, ST_C5: t <= MUL_W'(p15);
              ST_C2, ST_C4, ST_C6: c <= t + MUL_W'(p15);
              ST_G2, ST_G4: g2 <= p15[15:0];
              ST_DEN: begin
                idx  <= off[17:9];
                frac <= off[8:0];
              end
              ST_DIVA: begin
                ra <= quo;
                rc <= $signed({2'b00, quo});
              end
              ST_DIVB: rb <= quo;
              ST_INTP: rc <= $signed({2'b00, ra}) + MUL_W'(p9);
              ST_KC:   drv <= MUL_W'(x) - MUL_W'(p12);
              ST_DRV:  drv <= MUL_W'(soft_limit(dsc));
              ST_S0, ST_S1, ST_S2, ST_S3: begin
                drv <= y;
                case (step)
                  ST_S0:   s[0] <= soft_limit(21'(y) + p15);
                  ST_S1:   s[1] <= soft_limit(21'(y) + p15);
                  ST_S2:   s[2] <= soft_limit(21'(y) + p15);
                  default: s[3] <= soft_limit(21'(y) + p15);
                endcase
              end
              default: ;
            endcase
            if (step == ST_S3) begin
              state <= S_OUT;
              step  <= ST_C0;
            end else if ((step == ST_DIVA) && (idx == 9'd256)) begin
              // Top entry: no interpolation
              state <= S_ISSUE;
              step  <= ST_KC;
            end else begin
              state <= S_ISSUE;
              step  <= step_t'(step + 1'b1);
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_q <= soft_limit(21'(drv));
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign sample_out = out_q;

endmodule
